>>> rtl/core/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min/max contrast stretch unit.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int DIV_STEPS  = 8;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // low PIXEL_BITS of the pixel field are significant
    localparam logic [7:0] PIX_MASK = 8'((1 << PIXEL_BITS) - 1);
    localparam logic [7:0] LEVELS_RESET = 8'd255;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_STRETCH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [7:0] stretched;
        logic       flat_range;
    } t_out_word;

    typedef struct packed {
        logic load;      // word accepted this cycle
        logic mul;       // form diff * levels
        logic div_step;  // one restoring divide step
        logic finish;    // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_stretch;
    } t_dp_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

>>> rtl/core/min_max_contrast_stretch_unit.sv
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_unit
// Greyscale min/max contrast stretch over a frame sent in two passes.
// ----------------------------------------------------------------------------
// A measure word (kind 0) only updates the running minimum and maximum;
// frame_start restarts them. A stretch word (kind 1) gives one output word
// after the accept, the 8x8 multiply, eight steps of the bit-serial divider
// and the load of the output register, which waits while the output is not
// free. The output register lets the next word be accepted while a result
// still waits to be taken.
module min_max_contrast_stretch_unit
    import mmcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mmcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mmcs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.flat_range |-> o_out_word.stretched == 8'd0)
        else $error("flat range word with non-zero value");

    a_stretch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.kind == KIND_STRETCH) |=> !o_in_ready)
        else $error("ready after stretch word accepted");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("output word appeared without a stretch in progress");
`endif

endmodule

>>> rtl/core/mmcs_datapath.sv
// ----------------------------------------------------------------------------
// mmcs_datapath
// Min/max tracking, level register, multiplier and bit-serial divider.
// ----------------------------------------------------------------------------
module mmcs_datapath
    import mmcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  t_in_word   i_in_word,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_word  o_out_word
);

    logic [7:0]  r_min, r_max, r_levels;
    logic [7:0]  r_diff, r_range;
    logic        r_flat, r_sat;
    logic [7:0]  r_rem, r_quo;
    t_out_word   r_out;

    logic [7:0]  px;
    logic [7:0]  cur_min, cur_max;
    logic [7:0]  range_c, diff_c;
    logic [15:0] prod;
    logic [8:0]  trial;
    logic        qbit;

    assign px = i_in_word.pixel & PIX_MASK;

    // frame start restarts tracking before the pixel is taken in
    assign cur_min = i_in_word.frame_start ? PIX_MASK : r_min;
    assign cur_max = i_in_word.frame_start ? 8'd0 : r_max;

    assign range_c = r_max - r_min;
    assign diff_c  = (px > r_min) ? (px - r_min) : 8'd0;

    assign prod  = r_diff * r_levels;
    assign trial = {r_rem, r_quo[7]};
    assign qbit  = (trial >= {1'b0, r_range});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= PIX_MASK;
            r_max    <= '0;
            r_levels <= LEVELS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_levels <= i_cfg_wdata;
            end
            if (i_cmd.load && (i_in_word.kind == KIND_MEASURE)) begin
                r_min <= (px < cur_min) ? px : cur_min;
                r_max <= (px > cur_max) ? px : cur_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_diff  <= diff_c;
            r_range <= range_c;
            r_flat  <= (r_max <= r_min);
            // diff >= range means the quotient reaches levels at least
            r_sat   <= (diff_c >= range_c);
        end
        if (i_cmd.mul) begin
            // high byte seeds the remainder; it is below the divisor when not saturated
            r_rem <= prod[15:8];
            r_quo <= prod[7:0];
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? 8'(trial - {1'b0, r_range}) : trial[7:0];
            r_quo <= {r_quo[6:0], qbit};
        end
        if (i_cmd.finish) begin
            r_out.flat_range <= r_flat;
            if (r_flat) begin
                r_out.stretched <= '0;
            end else if (r_sat) begin
                r_out.stretched <= r_levels;
            end else begin
                r_out.stretched <= r_quo;
            end
        end
    end

    assign o_status.is_stretch = (i_in_word.kind == KIND_STRETCH);
    assign o_out_word = r_out;

endmodule

>>> rtl/core/mmcs_ctrl.sv
// ----------------------------------------------------------------------------
// mmcs_ctrl
// Sequencer for the stretch datapath and output word handshake.
// ----------------------------------------------------------------------------
module mmcs_ctrl
    import mmcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.load   = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_status.is_stretch) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the min/max contrast stretch unit.
// ----------------------------------------------------------------------------
// Measure and stretch words are fed through the input handshake with random
// gaps. The output side stalls at random, and once it holds off long enough
// to back the unit up. A local model of the running min/max and of the
// integer stretch predicts each output word, which is checked field by
// field. The output level is changed between phases while the unit is idle:
// reset value, zero, one, full scale and random values in between.
// ----------------------------------------------------------------------------
module testbench;
    import mmcs_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;   // idle wait after the last output word is taken

    typedef struct {
        t_in_word word;
        bit       drain_first;  // offer only once every output word is in
    } t_pending;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;

    t_pending   pixel_backlog[$];
    t_out_word  stretch_due[$];

    // running model of the unit
    logic [7:0] track_min  = PIX_MASK;
    logic [7:0] track_max  = '0;
    logic [7:0] out_levels = LEVELS_RESET;

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   hold_left = 0;
    bit   hold_req  = 1'b0;
    int   send_gap_max = 0;
    int   recv_gap_max = 0;
    int   items_queued = 0;
    int   bad_count    = 0;

    min_max_contrast_stretch_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out_word stretch_of(logic [7:0] px);
        t_out_word r;
        int span, delta, q;
        r = '0;
        // empty or never-measured range reads as flat
        if (track_max <= track_min) begin
            r.flat_range = 1'b1;
            return r;
        end
        span  = int'(track_max) - int'(track_min);
        delta = (px > track_min) ? int'(px) - int'(track_min) : 0;
        q     = (delta * int'(out_levels)) / span;
        if (q > int'(out_levels))
            q = int'(out_levels);
        r.stretched = 8'(q);
        return r;
    endfunction

    function automatic void take_word(t_in_word w);
        logic [7:0] px;
        px = w.pixel & PIX_MASK;
        if (w.kind == KIND_MEASURE) begin
            if (w.frame_start) begin
                track_min = PIX_MASK;
                track_max = '0;
            end
            if (px < track_min)
                track_min = px;
            if (px > track_max)
                track_max = px;
        end else begin
            stretch_due.push_back(stretch_of(px));
        end
    endfunction

    function automatic void note_bad(string msg);
        bad_count++;
        if (bad_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            in_taken   <= 1'b0;
            out_taken  <= 1'b0;
            track_min  = PIX_MASK;
            track_max  = '0;
            out_levels = LEVELS_RESET;
        end else begin
            in_taken  <= i_in_valid && o_in_ready;
            out_taken <= o_out_valid && i_out_ready;
            if (o_out_valid && i_out_ready) begin
                if (stretch_due.size() == 0) begin
                    note_bad($sformatf("output word %0d/%0b with none pending",
                                       o_out_word.stretched, o_out_word.flat_range));
                end else begin
                    want = stretch_due.pop_front();
                    if (o_out_word.stretched !== want.stretched ||
                        o_out_word.flat_range !== want.flat_range)
                        note_bad($sformatf("stretched/flat want %0d/%0b got %0d/%0b",
                                           want.stretched, want.flat_range,
                                           o_out_word.stretched, o_out_word.flat_range));
                end
            end
            // output checked first: a word taken now cannot be out yet
            if (i_in_valid && o_in_ready)
                take_word(i_in_word);
        end
    end

    // input side
    always @(negedge i_clk) begin
        t_pending nxt;
        logic     offer;
        offer = i_in_valid && !in_taken;
        if (i_rst_n && !offer) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (pixel_backlog.size() != 0 &&
                         (!pixel_backlog[0].drain_first || stretch_due.size() == 0)) begin
                nxt       = pixel_backlog.pop_front();
                i_in_word <= nxt.word;
                offer     = 1'b1;
                send_wait = $urandom_range(0, send_gap_max);
            end
        end
        i_in_valid <= offer;
    end

    // output side
    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (out_taken)
                recv_wait = $urandom_range(0, recv_gap_max);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            else if (recv_wait > 0)
                recv_wait--;
            else
                rdy = 1'b1;
        end
        i_out_ready <= rdy;
    end

    task automatic queue_pixel(logic kind, logic [7:0] px, logic fs, bit drain);
        t_pending p;
        p.word        = '{kind: kind, pixel: px, frame_start: fs};
        p.drain_first = drain;
        pixel_backlog.push_back(p);
        items_queued++;
    endtask

    // measure pass then stretch pass; mostly replays the measured pixels
    task automatic queue_frame(int n_meas, int n_str);
        logic [7:0] lo, hi, px;
        logic [7:0] seen[$];
        logic       fs;
        bit         pause;
        lo = 8'($urandom_range(0, 255));
        hi = ($urandom_range(0, 7) == 0) ? lo : 8'($urandom_range(lo, 255));
        for (int i = 0; i < n_meas; i++) begin
            px = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(lo, hi));
            fs = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
            seen.push_back(px);
            queue_pixel(KIND_MEASURE, px, fs, 1'b0);
        end
        pause = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_str; i++) begin
            if (i < seen.size() && $urandom_range(0, 3) != 0)
                px = seen[i];
            else
                px = 8'($urandom);
            queue_pixel(KIND_STRETCH, px, $urandom_range(0, 7) == 0, pause && i == 0);
        end
    endtask

    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (pixel_backlog.size() != 0 || i_in_valid || stretch_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_levels(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        out_levels = v;
    endtask

    initial begin
        int n, n_meas, extra, frames;
        logic [7:0] lv;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset level of 255
        queue_pixel(KIND_STRETCH, 8'h80, 1'b0, 1'b0);  // nothing measured yet
        queue_pixel(KIND_STRETCH, 8'hFF, 1'b1, 1'b0);  // frame start on stretch ignored
        queue_pixel(KIND_MEASURE, 8'h40, 1'b1, 1'b0);
        queue_pixel(KIND_STRETCH, 8'h40, 1'b0, 1'b0);  // zero range
        queue_pixel(KIND_MEASURE, 8'hC0, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'h00, 1'b0, 1'b0);  // under min
        queue_pixel(KIND_STRETCH, 8'hFF, 1'b0, 1'b0);  // over max, saturates
        queue_pixel(KIND_STRETCH, 8'h80, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'hC0, 1'b0, 1'b0);
        queue_pixel(KIND_MEASURE, 8'h00, 1'b1, 1'b0);
        queue_pixel(KIND_MEASURE, 8'hFF, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'h00, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'hFF, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'h55, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'hAA, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'h7F, 1'b1, 1'b0);
        wait_quiet();
        set_levels(8'd0);
        queue_pixel(KIND_STRETCH, 8'hFF, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'h80, 1'b0, 1'b0);
        wait_quiet();
        set_levels(8'd1);
        queue_pixel(KIND_STRETCH, 8'hFE, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'hFF, 1'b0, 1'b0);
        queue_pixel(KIND_STRETCH, 8'h00, 1'b0, 1'b0);
        wait_quiet();

        // back up the unit: long output hold against a steady input stream
        set_levels(8'd200);
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_req     = 1'b1;
        queue_frame(8, 60);
        wait_quiet();

        while (items_queued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       lv = 8'd0;
                1:       lv = 8'd1;
                2:       lv = 8'd255;
                default: lv = 8'($urandom_range(2, 254));
            endcase
            set_levels(lv);
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            frames = $urandom_range(2, 8);
            repeat (frames) begin
                n      = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(1, 24);
                n_meas = ($urandom_range(0, 15) == 0) ? 0 : n;
                extra  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                queue_frame(n_meas, n + extra);
            end
            wait_quiet();
        end

        wait_quiet();
        if (bad_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mmcs_pkg.sv
rtl/core/mmcs_datapath.sv
rtl/core/mmcs_ctrl.sv
rtl/core/min_max_contrast_stretch_unit.sv
tb/sv/testbench.sv
